>>> design/tlfsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the timed lowest-free-slot allocator.
// No dependencies; used by every module of the block.
package tlfsa_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned SLOT_W    = 7;
  localparam int unsigned USES_W    = 16;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned SLOTS_DEF = 64;

  localparam logic [CNT_W-1:0]  SLOT_COUNT_RST = CNT_W'(64);
  localparam logic [USES_W-1:0] USES_MAX       = '1;

  // A request as it travels down the row of cells, with the grant picked up so far.
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] departure;
    logic              served;
    logic [SLOT_W-1:0] slot;
    logic [USES_W-1:0] uses;
  } req_t;

endpackage

>>> design/tlfsa_cell.sv
`timescale 1ns / 1ps
// One slot of the allocator: holds the slot's free time, busy flag and use count,
// and passes each request on to the next slot through its request register. Uses tlfsa_pkg.
module tlfsa_cell
  import tlfsa_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [CNT_W-1:0] slot_count_i,
  input  req_t             req_i,
  output req_t             req_o
);

  localparam logic [SLOT_W-1:0] SlotNum = SLOT_W'(IDX + 1);

  logic [TIME_W-1:0] free_time_q, free_time_d;
  logic              occ_q, occ_d;
  logic [USES_W-1:0] uses_q, uses_d;
  req_t              req_q, req_d;

  logic expired, free_now, eligible, grant;

  always_comb begin
    expired  = (free_time_q <= req_i.arrival);
    free_now = !occ_q || expired;
    eligible = (32'(slot_count_i) > 32'(IDX));
    grant    = req_i.valid && free_now && eligible && !req_i.served;

    occ_d       = occ_q;
    free_time_d = free_time_q;
    uses_d      = uses_q;
    if (req_i.valid) begin
      // Freeing applies to every slot, eligible or not.
      occ_d = occ_q && !expired;
    end
    if (grant) begin
      occ_d       = 1'b1;
      free_time_d = req_i.departure;
      if (uses_q != USES_MAX) begin
        uses_d = uses_q + USES_W'(1);
      end
    end

    req_d = req_i;
    if (grant) begin
      req_d.served = 1'b1;
      req_d.slot   = SlotNum;
      req_d.uses   = uses_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= 1'b0;
      uses_q      <= '0;
      free_time_q <= '0;
      req_q       <= '0;
    end else if (en_i) begin
      occ_q       <= occ_d;
      uses_q      <= uses_d;
      free_time_q <= free_time_d;
      req_q       <= req_d;
    end
  end

  assign req_o = req_q;

endmodule

>>> design/tlfsa_out_buf.sv
`timescale 1ns / 1ps
// Output register with one skid entry behind it, so the cell row keeps moving
// while a finished result waits for the receiver. Uses tlfsa_pkg.
module tlfsa_out_buf
  import tlfsa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  output logic ready_o,
  output logic valid_o,
  output req_t data_o,
  input  logic ready_i
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  req_t out_q, out_d;
  req_t skid_q, skid_d;
  logic take;

  always_comb begin
    take         = out_valid_q && ready_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (req_i.valid) begin
      if (!out_valid_q || take) begin
        out_d       = req_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = req_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

>>> design/timed_lowest_free_slot_allocator_core.sv
`timescale 1ns / 1ps
// Timed lowest-free-slot allocator, top level: a row of slot cells and an
// output buffer. Depends on tlfsa_pkg, tlfsa_cell and tlfsa_out_buf.
//
// Each request on the slave stream carries an arrival and a departure time and
// should come in nondecreasing arrival order. A busy slot whose departure time is
// at or before the arrival is released, then the lowest free slot among the first
// slot_count slots is granted and remembers the departure time. One result leaves
// on the master stream for every request: a served flag in tuser, and the slot
// number (from 1) and its saturating use count in tdata, both zero when no slot
// was free.
// The request walks along a row of SLOTS cells, one cell per cycle while the row moves,
// so each slot sees the requests in order and a new request may enter every such cycle.
// A result passes the SLOTS cell registers, then the output register; throughput is one
// transfer per cycle while the row moves, set by the single pass through each cell.
// The configuration channel writes slot_count (values above SLOTS act as SLOTS);
// it is always ready and should only be written while the block is idle.
// Reset clears every slot to free with a zero use count and sets slot_count to
// 64. When the receiver stalls, the held result sits in the output register and
// one more result in a skid entry; only once both are full does the whole row
// freeze and s_axis_tready fall.
module timed_lowest_free_slot_allocator_core
  import tlfsa_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2*TIME_W-1:0] s_axis_tdata,  // arrival [31:0], departure [63:32]
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,  // slot [6:0], slot_uses [22:7], zero [23]
  output logic                m_axis_tuser,  // served
  // Configuration write channel: slot_count.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CNT_W-1:0]    cfg_data_i
);

  logic [CNT_W-1:0] slot_count_q;
  logic             en;
  req_t             chain [SLOTS+1];
  req_t             res;

  // The configuration register takes a transfer in any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_COUNT_RST;
    end else if (cfg_valid_i) begin
      slot_count_q <= cfg_data_i;
    end
  end

  // The row advances as one whenever the skid entry is free.
  assign s_axis_tready = en;

  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = s_axis_tvalid && en;
    chain[0].arrival   = s_axis_tdata[TIME_W-1:0];
    chain[0].departure = s_axis_tdata[2*TIME_W-1:TIME_W];
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    tlfsa_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .slot_count_i(slot_count_q),
      .req_i       (chain[i]),
      .req_o       (chain[i+1])
    );
  end

  tlfsa_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (chain[SLOTS]),
    .ready_o(en),
    .valid_o(m_axis_tvalid),
    .data_o (res),
    .ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, res.uses, res.slot};
  assign m_axis_tuser = res.served;

  // A refused request leaves slot number and count at zero.
  a_unserved_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (res.slot == '0 && res.uses == '0))
    else $error("unserved result carries a slot or count");

  // A grant names a slot within the configured count and a non-zero count.
  a_served_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (res.slot != '0 && 32'(res.slot) <= 32'(slot_count_q) && res.uses != '0))
    else $error("granted slot out of range or zero use count");

  // The input side only stalls when a result is already waiting at the output.
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with an empty output register");

  // A result refused by the receiver stays in place.
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule
